// ===== hw/rtl/mfbr_pkg.sv =====
// mfbr_pkg: sizes, widths and status codes for the MSB-first bit reader.
// No dependencies; imported by mfbr_ram, msb_first_bit_reader_top and tb.
package mfbr_pkg;

  localparam int BUFFER_BYTES  = 16;
  localparam int MAX_READ_BITS = 32;

  localparam int ADDR_W  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int COUNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int BITS_W  = COUNT_W + 3;           // holds BUFFER_BYTES * 8
  localparam int NBITS_W = 6;                     // bit_count field
  localparam int AVAIL_W = 8;                     // available_bits field
  localparam int VALUE_W = 32;                    // value field
  localparam int ACC_W   = MAX_READ_BITS;

  localparam logic [7:0] BYTE_MASK = 8'b11111111;
  localparam logic [7:0] BIT_ONE   = 8'b00000001;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_SHORT = 2'd2
  } status_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_BYTES - 1);

endpackage

// ===== hw/rtl/mfbr_ram.sv =====
// mfbr_ram: byte store for the bit reader, one write and one registered read port.
// Depends on mfbr_pkg for depth and address width.
module mfbr_ram
  import mfbr_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [BUFFER_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/msb_first_bit_reader_top.sv =====
// msb_first_bit_reader_top: byte FIFO with an MSB-first bit extractor.
// Depends on mfbr_pkg and mfbr_ram.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  kind, data_byte, bit_count
//   rsp      out        rsp_valid/rsp_stall  value, status, available_bits
//
// A load or a rejected/zero-length read passes through ST_DONE into the output register.
// A read works one byte per pass: a store read in ST_FETCH, then an extract in ST_TAKE
// taking up to eight bits; ST_FETCH waits out the registered read of the byte store.
// One item at a time; a finished result waits in the output register under rsp_stall
// while the next item is taken. Synchronous reset empties the FIFO; the store itself
// is not cleared.
module msb_first_bit_reader_top
  import mfbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 kind,
  input  logic [7:0]           data_byte,
  input  logic [NBITS_W-1:0]   bit_count,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [VALUE_W-1:0]   value,
  output logic [1:0]           status,
  output logic [AVAIL_W-1:0]   available_bits
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_TAKE  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [ADDR_W-1:0]    head;
  logic [COUNT_W-1:0]   count;
  logic [2:0]           offset;
  logic [NBITS_W-1:0]   remain;
  logic [ACC_W-1:0]     acc;
  status_t              res_status;

  logic                 accept;
  logic [BITS_W-1:0]    bits_left;
  logic                 full;
  logic                 short_read;
  logic [ADDR_W:0]      wr_sum;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 wr_en;
  logic [7:0]           rd_data;
  logic                 out_free;

  // extract datapath
  logic [3:0]           room;
  logic [3:0]           take;
  logic [3:0]           off_sum;
  logic [7:0]           field;
  logic                 byte_done;
  logic [NBITS_W-1:0]   remain_next;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign bits_left  = {count, 3'b000} - BITS_W'(offset);
  assign full       = (count >= COUNT_W'(BUFFER_BYTES));
  assign short_read = (bit_count > NBITS_W'(MAX_READ_BITS))
                   || (BITS_W'(bit_count) > bits_left);

  // tail address, wrapped without a divider
  assign wr_sum  = (ADDR_W+1)'(head) + (ADDR_W+1)'(count);
  assign wr_addr = (wr_sum >= (ADDR_W+1)'(BUFFER_BYTES))
                 ? ADDR_W'(wr_sum - (ADDR_W+1)'(BUFFER_BYTES))
                 : ADDR_W'(wr_sum);
  assign wr_en   = accept && !kind && !full;

  mfbr_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (data_byte),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  // bits of the head byte taken this pass: min(remain, 8 - offset)
  assign room        = 4'd8 - {1'b0, offset};
  assign take        = (remain < NBITS_W'(room)) ? remain[3:0] : room;
  assign field       = (rd_data >> (room - take)) & (BYTE_MASK >> (4'd8 - take));
  assign off_sum     = {1'b0, offset} + take;
  assign byte_done   = off_sum[3];
  assign remain_next = remain - NBITS_W'(take);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind && !short_read && (bit_count != '0)) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FETCH: state_next = ST_TAKE;
      ST_TAKE: begin
        if (remain_next == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      head   <= '0;
      count  <= '0;
      offset <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        count <= count + COUNT_W'(BIT_ONE);
      end
      if (state == ST_TAKE) begin
        offset <= off_sum[2:0];
        if (byte_done) begin
          head  <= (head == LAST_ADDR) ? '0 : head + ADDR_W'(BIT_ONE);
          count <= count - COUNT_W'(BIT_ONE);
        end
      end
    end
  end

  // item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      acc    <= '0;
      remain <= bit_count;
      if (!kind) begin
        res_status <= full ? STATUS_FULL : STATUS_OK;
      end else begin
        res_status <= short_read ? STATUS_SHORT : STATUS_OK;
      end
    end else if (state == ST_TAKE) begin
      acc    <= (acc << take) | ACC_W'(field);
      remain <= remain_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      value          <= VALUE_W'(acc);
      status         <= res_status;
      available_bits <= AVAIL_W'(bits_left);
    end
  end

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for msb_first_bit_reader_top (loads and MSB-first bit reads).
// Depends on mfbr_pkg and the RTL top; stimulus, driver, monitor and predictor live here.
// Directed corner items come first, then random load/read traffic with random idling on both sides.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfbr_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam int RANDOM_ITEMS = 1700;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic               kind;
    logic [7:0]         data;
    logic [NBITS_W-1:0] count;
  } bit_req_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [AVAIL_W-1:0] avail;
  } bit_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               kind = KIND_LOAD;
  logic [7:0]         data_byte = '0;
  logic [NBITS_W-1:0] bit_count = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [VALUE_W-1:0] value;
  logic [1:0]         status;
  logic [AVAIL_W-1:0] available_bits;

  msb_first_bit_reader_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .kind(kind), .data_byte(data_byte), .bit_count(bit_count),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .value(value), .status(status), .available_bits(available_bits)
  );

  bit_req_t   item_backlog[$];
  bit_reply_t expected_replies[$];

  // predictor state: bytes held, head first, and bits already taken from the head
  logic [7:0]  stream_bytes[$];
  int unsigned stream_bit_pos = 0;

  // bits held as seen by the stimulus generator, to steer the fill level
  int unsigned plan_bits = 0;

  int unsigned items_sent = 0, replies_seen = 0, fault_count = 0, cycle_count = 0;
  int unsigned loads_kept = 0, loads_dropped = 0, reads_ok = 0, reads_short = 0;
  int unsigned send_gap = 0, stall_left = 0;
  bit          req_quiet = 1'b0, rsp_quiet = 1'b0;

  initial forever #1 clk = ~clk;

  function automatic bit_reply_t bit_stream_predict(bit_req_t it);
    bit_reply_t  r;
    int unsigned left;
    int unsigned i;
    r.value  = '0;
    r.status = STATUS_OK;
    if (it.kind == KIND_LOAD) begin
      if (stream_bytes.size() >= BUFFER_BYTES) r.status = STATUS_FULL;
      else stream_bytes.push_back(it.data);
    end else begin
      left = stream_bytes.size() * 8 - stream_bit_pos;
      if (it.count > MAX_READ_BITS || it.count > left) begin
        r.status = STATUS_SHORT;
      end else begin
        for (i = 0; i < it.count; i++) begin
          r.value = {r.value[VALUE_W-2:0], stream_bytes[0][7 - stream_bit_pos]};
          stream_bit_pos++;
          if (stream_bit_pos == 8) begin
            stream_bit_pos = 0;
            void'(stream_bytes.pop_front());
          end
        end
      end
    end
    r.avail = AVAIL_W'(stream_bytes.size() * 8 - stream_bit_pos);
    return r;
  endfunction

  function automatic void enqueue_item(logic k, logic [7:0] d, logic [NBITS_W-1:0] c);
    bit_req_t it;
    it.kind  = k;
    it.data  = d;
    it.count = c;
    item_backlog.push_back(it);
    if (k == KIND_LOAD) begin
      if ((plan_bits + 7) / 8 < BUFFER_BYTES) plan_bits += 8;
    end else if (c <= MAX_READ_BITS && c <= plan_bits) begin
      plan_bits -= c;
    end
  endfunction

  // per-transfer wait, with occasional stretches of none at all
  function automatic int unsigned draw_idle(inout bit quiet);
    if ($urandom_range(0, 47) == 0) quiet = !quiet;
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic void log_fault(string msg);
    if (fault_count < 10) $display("mismatch: %s", msg);
    fault_count++;
  endfunction

  function automatic void build_stimulus();
    logic [7:0]  fill_bytes[8] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h7F, 8'hFE, 8'h80};
    int unsigned fill_target;
    int unsigned r, held, top;
    int unsigned i;
    // empty store: zero-length read, short read, over-length read
    enqueue_item(KIND_READ, 8'hFF, 6'd0);
    enqueue_item(KIND_READ, 8'h00, 6'd1);
    enqueue_item(KIND_READ, 8'hFF, 6'd63);
    enqueue_item(KIND_LOAD, 8'h80, 6'd63);
    enqueue_item(KIND_READ, 8'h00, 6'd1);
    enqueue_item(KIND_READ, 8'hFF, 6'd8);
    enqueue_item(KIND_READ, 8'h55, 6'd7);
    // fill to the brim, overflow once, then widest reads
    for (i = 0; i < BUFFER_BYTES; i++)
      enqueue_item(KIND_LOAD, (i < 8) ? fill_bytes[i] : 8'($urandom), 6'($urandom));
    enqueue_item(KIND_LOAD, 8'h3C, 6'd32);
    enqueue_item(KIND_READ, 8'h00, 6'd33);
    enqueue_item(KIND_READ, 8'hAA, 6'd32);
    enqueue_item(KIND_READ, 8'h0F, 6'd5);

    fill_target = 8;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 49) == 0) fill_target = $urandom_range(1, BUFFER_BYTES);
      r    = $urandom_range(0, 99);
      held = (plan_bits + 7) / 8;
      top  = (plan_bits < MAX_READ_BITS) ? plan_bits : MAX_READ_BITS;
      if (r < 4) begin
        enqueue_item(KIND_LOAD, 8'($urandom), 6'($urandom));
      end else if (r < 9) begin
        enqueue_item(KIND_READ, 8'($urandom), 6'($urandom));
      end else if (held < fill_target && r < 85) begin
        enqueue_item(KIND_LOAD, 8'($urandom), 6'($urandom));
      end else if (r % 8 == 0) begin
        enqueue_item(KIND_READ, 8'($urandom), 6'(top));
      end else begin
        enqueue_item(KIND_READ, 8'($urandom), 6'($urandom_range(0, top)));
      end
    end
  endfunction

  // request side: predict on every accepted transfer, then present the next item
  always @(posedge clk) begin
    bit_req_t   it;
    bit_reply_t want;
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        it.kind  = kind;
        it.data  = data_byte;
        it.count = bit_count;
        want = bit_stream_predict(it);
        expected_replies.push_back(want);
        items_sent++;
        case (want.status)
          STATUS_FULL:  loads_dropped++;
          STATUS_SHORT: reads_short++;
          default: begin
            if (it.kind == KIND_LOAD) loads_kept++;
            else reads_ok++;
          end
        endcase
      end
      if (!req_valid || !req_stall) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          it = item_backlog.pop_front();
          kind      <= it.kind;
          data_byte <= it.data;
          bit_count <= it.count;
          req_valid <= 1'b1;
          send_gap  <= draw_idle(req_quiet);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result side: check each transfer against the oldest expectation
  always @(posedge clk) begin
    bit_reply_t  want;
    int unsigned w;
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        log_fault($sformatf("result with nothing expected: value %h status %0d avail %0d",
                            value, status, available_bits));
      end else begin
        want = expected_replies.pop_front();
        if (value !== want.value || status !== want.status || available_bits !== want.avail)
          log_fault($sformatf("result %0d: want value %h status %0d avail %0d, got %h %0d %0d",
                              replies_seen, want.value, want.status, want.avail,
                              value, status, available_bits));
      end
      w = draw_idle(rsp_quiet);
      rsp_stall  <= (w != 0);
      stall_left <= (w == 0) ? 0 : w - 1;
    end else if (stall_left != 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_replies.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned total_items;
    build_stimulus();
    total_items = item_backlog.size();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (items_sent < total_items || expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0)
      log_fault($sformatf("%0d results never arrived", expected_replies.size()));
    $display("%0d items: %0d loads kept, %0d dropped on a full store, %0d reads, %0d too short",
             items_sent, loads_kept, loads_dropped, reads_ok, reads_short);
    $display("%0d results checked over %0d cycles, %0d mismatches",
             replies_seen, cycle_count, fault_count);
    if (fault_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
